// File: src/wsps_pkg.sv
// Package of the addressed-LED pixel serializer.
// Holds the shared item, result and configuration types and the register map.
// No dependencies.
package wsps_pkg;

   // Register indexes on the configuration port (byte address = 4 * index).
   localparam logic [2:0] REG_TICKS_PER_UNIT   = 3'd0;
   localparam logic [2:0] REG_ZERO_HIGH_UNITS  = 3'd1;
   localparam logic [2:0] REG_ONE_HIGH_UNITS   = 3'd2;
   localparam logic [2:0] REG_BIT_PERIOD_UNITS = 3'd3;
   localparam logic [2:0] REG_LATCH_UNITS      = 3'd4;

   localparam logic [7:0]  RST_TICKS_PER_UNIT   = 8'd4;
   localparam logic [5:0]  RST_ZERO_HIGH_UNITS  = 6'd8;
   localparam logic [5:0]  RST_ONE_HIGH_UNITS   = 6'd16;
   localparam logic [5:0]  RST_BIT_PERIOD_UNITS = 6'd24;
   localparam logic [11:0] RST_LATCH_UNITS      = 12'd1001;

   // Input item kinds.
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef struct packed {
      logic [7:0]  ticks_per_unit;
      logic [5:0]  zero_high_units;
      logic [5:0]  one_high_units;
      logic [5:0]  bit_period_units;
      logic [11:0] latch_units;
   } cfg_type;

   typedef struct packed {
      logic        func;
      logic [23:0] pixel_rgb;
      logic        end_of_frame;
   } item_type;

   typedef struct packed {
      logic frame_done;
      logic busy_res;
      logic accepted;
      logic pin_level;
   } result_type;

endpackage

// File: src/wsps_csr.sv
// Configuration register file of the pixel serializer, on an APB-style port.
// Depends on wsps_pkg for the register map and the configuration struct.
module wsps_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output wsps_pkg::cfg_type cfg
);

   wsps_pkg::cfg_type cfg_ff;
   wsps_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [2:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            wsps_pkg::REG_TICKS_PER_UNIT:   cfg_in.ticks_per_unit   = csr_pwdata[7:0];
            wsps_pkg::REG_ZERO_HIGH_UNITS:  cfg_in.zero_high_units  = csr_pwdata[5:0];
            wsps_pkg::REG_ONE_HIGH_UNITS:   cfg_in.one_high_units   = csr_pwdata[5:0];
            wsps_pkg::REG_BIT_PERIOD_UNITS: cfg_in.bit_period_units = csr_pwdata[5:0];
            wsps_pkg::REG_LATCH_UNITS:      cfg_in.latch_units      = csr_pwdata[11:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_unit   <= wsps_pkg::RST_TICKS_PER_UNIT;
         cfg_ff.zero_high_units  <= wsps_pkg::RST_ZERO_HIGH_UNITS;
         cfg_ff.one_high_units   <= wsps_pkg::RST_ONE_HIGH_UNITS;
         cfg_ff.bit_period_units <= wsps_pkg::RST_BIT_PERIOD_UNITS;
         cfg_ff.latch_units      <= wsps_pkg::RST_LATCH_UNITS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         wsps_pkg::REG_TICKS_PER_UNIT:   csr_prdata = {24'd0, cfg_ff.ticks_per_unit};
         wsps_pkg::REG_ZERO_HIGH_UNITS:  csr_prdata = {26'd0, cfg_ff.zero_high_units};
         wsps_pkg::REG_ONE_HIGH_UNITS:   csr_prdata = {26'd0, cfg_ff.one_high_units};
         wsps_pkg::REG_BIT_PERIOD_UNITS: csr_prdata = {26'd0, cfg_ff.bit_period_units};
         wsps_pkg::REG_LATCH_UNITS:      csr_prdata = {20'd0, cfg_ff.latch_units};
         default:                        csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: src/wsps_core.sv
// Serializer state and next-state logic: one-deep pixel buffer, bit shifter,
// unit prescaler and phase sequencer. Depends on wsps_pkg.
module wsps_core #(
   parameter int PIXEL_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wsps_pkg::cfg_type    cfg,
   input  logic                 step,
   input  wsps_pkg::item_type   item,
   output wsps_pkg::result_type res
);

   localparam int BL_W = $clog2(PIXEL_BITS);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_HIGH  = 2'd1;
   localparam logic [1:0] PH_LOW   = 2'd2;
   localparam logic [1:0] PH_LATCH = 2'd3;

   logic [PIXEL_BITS-1:0] shift_word_ff, shift_word_in;
   logic [BL_W-1:0]       bits_left_ff, bits_left_in;
   logic [1:0]            phase_ff, phase_in;
   logic [11:0]           unit_countdown_ff, unit_countdown_in;
   logic [7:0]            prescale_ff, prescale_in;
   logic [23:0]           held_pixel_ff, held_pixel_in;
   logic                  held_valid_ff, held_valid_in;
   logic                  held_last_ff, held_last_in;
   logic                  current_last_ff, current_last_in;

   logic [23:0]           grb;
   logic [PIXEL_BITS-1:0] load_word;
   logic [PIXEL_BITS-1:0] next_word;
   logic [7:0]            tpu;
   logic [5:0]            cur_high;
   logic [5:0]            load_high;
   logic [5:0]            next_high;
   logic [11:0]           cnt_dec;
   logic                  unit_end;
   logic                  accepted;
   logic                  done;

   function automatic logic [5:0] high_units(input logic b, input wsps_pkg::cfg_type c);
      logic [5:0] u;
      u = b ? c.one_high_units : c.zero_high_units;
      return (u == 6'd0) ? 6'd1 : u;
   endfunction

   assign grb       = {held_pixel_ff[15:8], held_pixel_ff[23:16], held_pixel_ff[7:0]};
   assign load_word = PIXEL_BITS'(grb) << (PIXEL_BITS - 24);
   assign next_word = shift_word_ff << 1;
   assign tpu       = (cfg.ticks_per_unit == 8'd0) ? 8'd1 : cfg.ticks_per_unit;
   assign cur_high  = high_units(shift_word_ff[PIXEL_BITS-1], cfg);
   assign load_high = high_units(load_word[PIXEL_BITS-1], cfg);
   assign next_high = high_units(next_word[PIXEL_BITS-1], cfg);
   assign unit_end  = ({1'b0, prescale_ff} + 9'd1) >= {1'b0, tpu};
   assign cnt_dec   = (unit_countdown_ff != 12'd0) ? unit_countdown_ff - 12'd1 : 12'd0;

   always_comb begin
      shift_word_in     = shift_word_ff;
      bits_left_in      = bits_left_ff;
      phase_in          = phase_ff;
      unit_countdown_in = unit_countdown_ff;
      prescale_in       = prescale_ff;
      held_pixel_in     = held_pixel_ff;
      held_valid_in     = held_valid_ff;
      held_last_in      = held_last_ff;
      current_last_in   = current_last_ff;
      accepted          = 1'b0;
      done              = 1'b0;

      if (item.func == wsps_pkg::FUNC_PUSH) begin
         // A push while the buffer is full is dropped.
         if (!held_valid_ff) begin
            held_pixel_in = item.pixel_rgb;
            held_last_in  = item.end_of_frame;
            held_valid_in = 1'b1;
            accepted      = 1'b1;
         end
      end else if (phase_ff == PH_IDLE) begin
         if (held_valid_ff) begin
            shift_word_in     = load_word;
            bits_left_in      = BL_W'(PIXEL_BITS - 1);
            current_last_in   = held_last_ff;
            held_valid_in     = 1'b0;
            phase_in          = PH_HIGH;
            unit_countdown_in = {6'd0, load_high};
            prescale_in       = 8'd0;
         end
      end else if (!unit_end) begin
         prescale_in = prescale_ff + 8'd1;
      end else begin
         prescale_in       = 8'd0;
         unit_countdown_in = cnt_dec;
         if (cnt_dec == 12'd0) begin
            if (phase_ff == PH_LATCH) begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end else if (phase_ff == PH_HIGH && cfg.bit_period_units > cur_high) begin
               phase_in          = PH_LOW;
               unit_countdown_in = {6'd0, cfg.bit_period_units - cur_high};
            end else begin
               // End of the bit: next bit, latch time, next pixel or idle.
               priority if (bits_left_ff != '0) begin
                  bits_left_in      = bits_left_ff - BL_W'(1);
                  shift_word_in     = next_word;
                  phase_in          = PH_HIGH;
                  unit_countdown_in = {6'd0, next_high};
               end else if (current_last_ff) begin
                  phase_in          = PH_LATCH;
                  unit_countdown_in = (cfg.latch_units == 12'd0) ? 12'd1 : cfg.latch_units;
               end else if (held_valid_ff) begin
                  shift_word_in     = load_word;
                  bits_left_in      = BL_W'(PIXEL_BITS - 1);
                  current_last_in   = held_last_ff;
                  held_valid_in     = 1'b0;
                  phase_in          = PH_HIGH;
                  unit_countdown_in = {6'd0, load_high};
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_word_ff     <= '0;
         bits_left_ff      <= '0;
         phase_ff          <= PH_IDLE;
         unit_countdown_ff <= '0;
         prescale_ff       <= '0;
         held_valid_ff     <= 1'b0;
         held_last_ff      <= 1'b0;
         current_last_ff   <= 1'b0;
      end else if (step) begin
         shift_word_ff     <= shift_word_in;
         bits_left_ff      <= bits_left_in;
         phase_ff          <= phase_in;
         unit_countdown_ff <= unit_countdown_in;
         prescale_ff       <= prescale_in;
         held_valid_ff     <= held_valid_in;
         held_last_ff      <= held_last_in;
         current_last_ff   <= current_last_in;
      end
   end

   // The buffered pixel itself needs no reset.
   always_ff @(posedge clock) begin
      if (step) begin
         held_pixel_ff <= held_pixel_in;
      end
   end

   assign res.pin_level  = (phase_in == PH_HIGH);
   assign res.accepted   = accepted;
   assign res.busy_res   = (phase_in != PH_IDLE);
   assign res.frame_done = done;

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (unit_countdown_ff != 12'd0))
      else $error("active phase with an empty unit countdown");

   a_done_from_latch: assert property (@(posedge clock) disable iff (reset)
      (step && res.frame_done) |-> (phase_ff == PH_LATCH))
      else $error("frame done outside the latch phase");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (step && res.accepted) |=> held_valid_ff)
      else $error("accepted pixel not held in the buffer");

   a_idle_load: assert property (@(posedge clock) disable iff (reset)
      (step && item.func == wsps_pkg::FUNC_TICK && phase_ff == PH_IDLE && held_valid_ff)
      |=> (!held_valid_ff && phase_ff == PH_HIGH))
      else $error("buffered pixel not started from idle");

endmodule

// File: src/ws2812_pixel_serializer.sv
// Addressed-LED pixel serializer, top level.
// An accepted beat passes from the input register through one step of the phase
// sequencer into the result register; a stalled result stream holds it back.
// Throughput: one beat per cycle while the result stream drains.
// Reset (synchronous, active high): line idle and low, buffer empty, timing
// registers at their defaults; no clearing pass.
module ws2812_pixel_serializer #(
   parameter int PIXEL_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] pixel_rgb
   input  logic        req_tuser,   // [0] func
   input  logic        req_tlast,   // end_of_frame
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] pin_level, [1] accepted, [2] busy_res,
                                    // [3] frame_done, [7:4] zero
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   wsps_pkg::cfg_type    cfg;
   wsps_pkg::item_type   in_item_ff;
   wsps_pkg::result_type res;
   wsps_pkg::result_type out_res_ff;
   logic                 in_valid_ff;
   logic                 out_valid_ff;
   logic                 out_load;

   wsps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // A beat moves from the input register to the result register whenever
   // the result register is empty or being drained.
   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.func         <= req_tuser;
         in_item_ff.pixel_rgb    <= req_tdata;
         in_item_ff.end_of_frame <= req_tlast;
      end
   end

   wsps_core #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .step  (out_load),
      .item  (in_item_ff),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_res_ff};

endmodule

// File: tb/wsps_line_checker.sv
`timescale 1ns / 1ps
// Result checker for the addressed-LED pixel serializer: follows the request, result and
// register ports, predicts the line state after every request beat and compares results.
// Depends on wsps_pkg for item kinds, register indexes and the result layout.
module wsps_line_checker #(
   parameter int PIXEL_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] pixel_rgb
   input  logic        req_tuser,   // [0] func
   input  logic        req_tlast,   // end_of_frame
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [0] pin_level, [1] accepted, [2] busy_res,
                                    // [3] frame_done, [7:4] zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          pending_count
);

   typedef enum logic [1:0] {LINE_IDLE, LINE_HIGH, LINE_LOW, LINE_LATCH} line_phase_type;

   wsps_pkg::cfg_type     cfg;
   logic [PIXEL_BITS-1:0] shift_word;
   logic [4:0]            bits_left;
   line_phase_type        phase;
   logic [11:0]           unit_countdown;
   logic [7:0]            prescale_count;
   logic [23:0]           held_pixel;
   logic                  held_valid;
   logic                  held_last;
   logic                  current_last;

   wsps_pkg::result_type  line_results_q[$];

   // High time of the bit now at the top of the shift word; zero counts as one unit.
   function automatic logic [5:0] high_units();
      logic [5:0] u;
      u = shift_word[PIXEL_BITS-1] ? cfg.one_high_units : cfg.zero_high_units;
      return (u == 6'd0) ? 6'd1 : u;
   endfunction

   function automatic void start_bit();
      phase          = LINE_HIGH;
      unit_countdown = {6'd0, high_units()};
      prescale_count = '0;
   endfunction

   // The buffered pixel goes out as G, R, B, most significant bit first.
   function automatic void load_pixel();
      logic [PIXEL_BITS-1:0] w;
      w = '0;
      w[PIXEL_BITS-1 -: 24] = {held_pixel[15:8], held_pixel[23:16], held_pixel[7:0]};
      shift_word   = w;
      bits_left    = 5'(PIXEL_BITS - 1);
      current_last = held_last;
      held_valid   = 1'b0;
      start_bit();
   endfunction

   function automatic void end_bit();
      if (bits_left != 0) begin
         bits_left  = bits_left - 5'd1;
         shift_word = shift_word << 1;
         start_bit();
      end else if (current_last) begin
         phase          = LINE_LATCH;
         unit_countdown = (cfg.latch_units == 12'd0) ? 12'd1 : cfg.latch_units;
         prescale_count = '0;
      end else if (held_valid) begin
         load_pixel();
      end else begin
         phase = LINE_IDLE;
      end
   endfunction

   function automatic wsps_pkg::result_type advance_line(logic func, logic [23:0] pix,
                                                         logic eof);
      wsps_pkg::result_type r;
      logic                 took;
      logic                 done;
      int                   tpu;
      logic [5:0]           hi;
      took = 1'b0;
      done = 1'b0;
      if (func == wsps_pkg::FUNC_PUSH) begin
         // A push into a full buffer is dropped.
         if (!held_valid) begin
            held_pixel = pix;
            held_last  = eof;
            held_valid = 1'b1;
            took       = 1'b1;
         end
      end else if (phase == LINE_IDLE) begin
         if (held_valid)
            load_pixel();
      end else begin
         tpu = (cfg.ticks_per_unit == 8'd0) ? 1 : int'(cfg.ticks_per_unit);
         if (int'(prescale_count) + 1 >= tpu) begin
            prescale_count = '0;
            if (unit_countdown != 0)
               unit_countdown = unit_countdown - 12'd1;
            if (unit_countdown == 0) begin
               if (phase == LINE_HIGH) begin
                  hi = high_units();
                  // With the period not above the high time, the low part is skipped.
                  if (cfg.bit_period_units > hi) begin
                     phase          = LINE_LOW;
                     unit_countdown = {6'd0, cfg.bit_period_units - hi};
                  end else begin
                     end_bit();
                  end
               end else if (phase == LINE_LOW) begin
                  end_bit();
               end else begin
                  phase = LINE_IDLE;
                  done  = 1'b1;
               end
            end
         end else begin
            prescale_count = prescale_count + 8'd1;
         end
      end
      r.pin_level  = (phase == LINE_HIGH);
      r.accepted   = took;
      r.busy_res   = (phase != LINE_IDLE);
      r.frame_done = done;
      return r;
   endfunction

   // Sampling on the falling edge sees exactly what the next rising edge will take.
   always @(negedge clock) begin
      wsps_pkg::result_type got;
      wsps_pkg::result_type want;
      if (reset) begin
         cfg = '{wsps_pkg::RST_TICKS_PER_UNIT, wsps_pkg::RST_ZERO_HIGH_UNITS,
                 wsps_pkg::RST_ONE_HIGH_UNITS, wsps_pkg::RST_BIT_PERIOD_UNITS,
                 wsps_pkg::RST_LATCH_UNITS};
         shift_word     = '0;
         bits_left      = '0;
         phase          = LINE_IDLE;
         unit_countdown = '0;
         prescale_count = '0;
         held_pixel     = '0;
         held_valid     = 1'b0;
         held_last      = 1'b0;
         current_last   = 1'b0;
         line_results_q.delete();
         mismatch_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               wsps_pkg::REG_TICKS_PER_UNIT:   cfg.ticks_per_unit   = csr_pwdata[7:0];
               wsps_pkg::REG_ZERO_HIGH_UNITS:  cfg.zero_high_units  = csr_pwdata[5:0];
               wsps_pkg::REG_ONE_HIGH_UNITS:   cfg.one_high_units   = csr_pwdata[5:0];
               wsps_pkg::REG_BIT_PERIOD_UNITS: cfg.bit_period_units = csr_pwdata[5:0];
               wsps_pkg::REG_LATCH_UNITS:      cfg.latch_units      = csr_pwdata[11:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            line_results_q.push_back(advance_line(req_tuser, req_tdata, req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            got = wsps_pkg::result_type'(rsp_tdata[3:0]);
            if (line_results_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result beat %b arrived with nothing predicted",
                           $realtime, rsp_tdata);
            end else begin
               want = line_results_q.pop_front();
               if (got.pin_level !== want.pin_level || got.accepted !== want.accepted ||
                   got.busy_res !== want.busy_res || got.frame_done !== want.frame_done) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: result mismatch: expected pin %b accepted %b busy %b ",
                               "done %b, got pin %b accepted %b busy %b done %b"},
                              $realtime, want.pin_level, want.accepted, want.busy_res,
                              want.frame_done, got.pin_level, got.accepted, got.busy_res,
                              got.frame_done);
               end
            end
         end
      end
      pending_count = line_results_q.size();
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the addressed-LED pixel serializer: clock, reset, bursty request
// stimulus, timing register writes, a stalling result sink and the verdict.
// Depends on wsps_pkg, ws2812_pixel_serializer and wsps_line_checker.
module tb;

   typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HALF, SINK_CHOKED} sink_mode_type;

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_tvalid  = 1'b0;
   logic          req_tready;
   logic [23:0]   req_tdata   = '0;
   logic          req_tuser   = wsps_pkg::FUNC_TICK;
   logic          req_tlast   = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready  = 1'b0;
   logic [7:0]    rsp_tdata;
   logic          csr_psel    = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite  = 1'b0;
   logic [4:0]    csr_paddr   = '0;
   logic [31:0]   csr_pwdata  = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;
   int            mismatch_count;
   int            pending_count;

   sink_mode_type sink_mode = SINK_OPEN;
   int            sink_left = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ws2812_pixel_serializer #(.PIXEL_BITS(24)) i_dut (.*);

   wsps_line_checker #(.PIXEL_BITS(24)) i_checker (.*);

   // The sink switches at random between stall patterns.
   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(0, 3));
         sink_left <= int'($urandom_range(8, 80));
      end else begin
         sink_left <= sink_left - 1;
      end
      case (sink_mode)
         SINK_OPEN:  rsp_tready <= 1'b1;
         SINK_LIGHT: rsp_tready <= ($urandom_range(0, 3) != 0);
         SINK_HALF:  rsp_tready <= ($urandom_range(0, 1) != 0);
         default:    rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic send_beat(input logic func, input logic [23:0] pix, input logic eof);
      logic seen;
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= pix;
      req_tlast  <= eof;
      do begin
         @(negedge clock);
         seen = req_tready;
         @(posedge clock);
      end while (!seen);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      logic seen;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         seen = csr_pready;
         @(posedge clock);
      end while (!seen);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      while (pending_count != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(input wsps_pkg::cfg_type c);
      drain_results();
      csr_write(wsps_pkg::REG_TICKS_PER_UNIT, 32'(c.ticks_per_unit));
      csr_write(wsps_pkg::REG_ZERO_HIGH_UNITS, 32'(c.zero_high_units));
      csr_write(wsps_pkg::REG_ONE_HIGH_UNITS, 32'(c.one_high_units));
      csr_write(wsps_pkg::REG_BIT_PERIOD_UNITS, 32'(c.bit_period_units));
      csr_write(wsps_pkg::REG_LATCH_UNITS, 32'(c.latch_units));
   endtask

   // Mostly ticks with an occasional pushed pixel, in bursts separated by short gaps.
   task automatic run_random(input int count, input int push_pct);
      int   sent;
      int   burst;
      logic func;
      sent = 0;
      while (sent < count) begin
         burst = int'($urandom_range(1, 24));
         for (int k = 0; k < burst && sent < count; k++) begin
            func = (int'($urandom_range(0, 99)) < push_pct) ? wsps_pkg::FUNC_PUSH
                                                             : wsps_pkg::FUNC_TICK;
            send_beat(func, 24'($urandom()), ($urandom_range(0, 3) == 0));
            sent++;
         end
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      wsps_pkg::cfg_type setting;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Default timing: a pixel only gets partway out before the timing changes.
      run_random(150, 10);

      apply_setting(wsps_pkg::cfg_type'{8'd1, 6'd1, 6'd2, 6'd3, 12'd2});
      // A tick with nothing buffered, a push, a push into the full buffer, a load,
      // a second pixel queued behind the first and one more dropped.
      send_beat(wsps_pkg::FUNC_TICK, 24'hFFFFFF, 1'b1);
      send_beat(wsps_pkg::FUNC_PUSH, 24'h000000, 1'b0);
      send_beat(wsps_pkg::FUNC_PUSH, 24'hFFFFFF, 1'b1);
      send_beat(wsps_pkg::FUNC_TICK, 24'h000000, 1'b0);
      send_beat(wsps_pkg::FUNC_PUSH, 24'hFFFFFF, 1'b1);
      send_beat(wsps_pkg::FUNC_PUSH, 24'hA5C33C, 1'b0);
      send_beat(wsps_pkg::FUNC_TICK, 24'h5A3CC3, 1'b1);
      send_beat(wsps_pkg::FUNC_TICK, 24'h000000, 1'b0);
      run_random(250, 4);

      // Zero time registers act as one, and the low part of each bit is skipped.
      apply_setting(wsps_pkg::cfg_type'{8'd0, 6'd0, 6'd0, 6'd0, 12'd0});
      run_random(200, 6);

      // One bits have no low part, zero bits do.
      apply_setting(wsps_pkg::cfg_type'{8'd2, 6'd1, 6'd3, 6'd2, 12'd5});
      run_random(200, 3);

      apply_setting(wsps_pkg::cfg_type'{8'd1, 6'd63, 6'd63, 6'd63, 12'd4095});
      run_random(100, 5);

      apply_setting(wsps_pkg::cfg_type'{8'd255, 6'd1, 6'd1, 6'd2, 12'd1});
      run_random(100, 5);

      setting.ticks_per_unit   = 8'($urandom_range(0, 3));
      setting.zero_high_units  = 6'($urandom_range(0, 4));
      setting.one_high_units   = 6'($urandom_range(0, 4));
      setting.bit_period_units = 6'($urandom_range(0, 6));
      setting.latch_units      = 12'($urandom_range(0, 8));
      apply_setting(setting);
      run_random(250, 4);

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// File: filelist.f
src/wsps_pkg.sv
src/wsps_csr.sv
src/wsps_core.sv
src/ws2812_pixel_serializer.sv
tb/wsps_line_checker.sv
tb/tb.sv
